[rtl/core/spq_pkg.sv]
// Shared constants, codes and control types for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY = 32;

    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_DISPLAY = 2'd1;
    localparam logic [1:0] ACT_SEARCH  = 2'd2;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FOUND    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_LISTED   = 3'd5
    } t_status;

    typedef struct packed {
        logic capture;
        logic insert;
        logic rotate;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic found;
    } t_dp_stat;

endpackage

[rtl/core/sorted_priority_queue_top.sv]
// Top level of the sorted priority queue: controller and datapath.
//
//  channel   handshake            payload
//  command   start & !busy        i_action, i_item_value, i_item_priority
//  result    o_strobe (1 cycle)   o_status, o_out_value, o_out_priority, o_last
//
// Insert and search are accepted in IDLE and finish in EXEC: the per-cell compares
// are registered on accept, and EXEC shifts the cells or reduces the match bits.
// Display goes from EXEC to DISP, where the cells rotate once per listed entry.
// Unused action code 3 passes through EXEC and gives no result.
// Synchronous active-low reset empties the store; no clearing pass is needed.
// Results cannot be stalled; each stands on the ports for one cycle.
module sorted_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_item_value,
    input  logic signed [31:0] i_item_priority,
    output logic               o_strobe,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_out_value,
    output logic signed [31:0] o_out_priority,
    output logic               o_last
);

    spq_pkg::t_dp_cmd   w_cmd;
    spq_pkg::t_dp_stat  w_stat;
    logic [CW-1:0]      w_count;
    logic signed [31:0] w_head_value;
    logic signed [31:0] w_head_priority;

    spq_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .o_cmd          (w_cmd),
        .i_stat         (w_stat),
        .i_count        (w_count),
        .i_head_value   (w_head_value),
        .i_head_priority(w_head_priority),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_last         (o_last)
    );

    spq_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_item_value   (i_item_value),
        .i_item_priority(i_item_priority),
        .o_stat         (w_stat),
        .o_count        (w_count),
        .o_head_value   (w_head_value),
        .o_head_priority(w_head_priority)
    );

endmodule

[rtl/core/spq_datapath.sv]
// Datapath of the sorted priority queue: entry cells, per-cell compares, shift and rotate.
module spq_datapath #(
    parameter int CAPACITY = spq_pkg::CAPACITY,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spq_pkg::t_dp_cmd    i_cmd,
    input  logic signed [31:0]  i_item_value,
    input  logic signed [31:0]  i_item_priority,
    output spq_pkg::t_dp_stat   o_stat,
    output logic [CW-1:0]       o_count,
    output logic signed [31:0]  o_head_value,
    output logic signed [31:0]  o_head_priority
);

    logic signed [31:0] r_val [CAPACITY];
    logic signed [31:0] r_pri [CAPACITY];
    logic signed [31:0] n_val [CAPACITY];
    logic signed [31:0] n_pri [CAPACITY];
    logic signed [31:0] r_key_val;
    logic signed [31:0] r_key_pri;
    logic [CAPACITY-1:0] r_le;
    logic [CAPACITY-1:0] r_eq;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       w_tail;

    assign w_tail = r_count - CW'(1);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [31:0] w_up_val;
        logic signed [31:0] w_up_pri;
        logic signed [31:0] w_dn_val;
        logic signed [31:0] w_dn_pri;
        logic               w_prev_le;

        if (i == 0) begin : g_first
            assign w_dn_val  = r_key_val;
            assign w_dn_pri  = r_key_pri;
            assign w_prev_le = 1'b1;
        end else begin : g_rest
            assign w_dn_val  = r_val[i-1];
            assign w_dn_pri  = r_pri[i-1];
            assign w_prev_le = r_le[i-1];
        end

        if (i == CAPACITY - 1) begin : g_end
            assign w_up_val = r_val[0];
            assign w_up_pri = r_pri[0];
        end else begin : g_mid
            assign w_up_val = (CW'(i) == w_tail) ? r_val[0] : r_val[i+1];
            assign w_up_pri = (CW'(i) == w_tail) ? r_pri[0] : r_pri[i+1];
        end

        always_comb begin
            n_val[i] = r_val[i];
            n_pri[i] = r_pri[i];
            if (i_cmd.insert && !r_le[i]) begin
                if (w_prev_le) begin
                    n_val[i] = r_key_val;
                    n_pri[i] = r_key_pri;
                end else begin
                    n_val[i] = w_dn_val;
                    n_pri[i] = w_dn_pri;
                end
            end else if (i_cmd.rotate && CW'(i) < r_count) begin
                n_val[i] = w_up_val;
                n_pri[i] = w_up_pri;
            end
        end

        always_ff @(posedge i_clk) begin
            r_val[i] <= n_val[i];
            r_pri[i] <= n_pri[i];
            if (i_cmd.capture) begin
                r_le[i] <= (CW'(i) < r_count) && (r_pri[i] <= i_item_priority);
                r_eq[i] <= (CW'(i) < r_count) && (r_val[i] == i_item_value);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.insert) begin
            r_count <= r_count + CW'(1);
        end
        if (i_cmd.capture) begin
            r_key_val <= i_item_value;
            r_key_pri <= i_item_priority;
        end
    end

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CW'(CAPACITY));
    assign o_stat.found    = |r_eq;
    assign o_count         = r_count;
    assign o_head_value    = r_val[0];
    assign o_head_priority = r_pri[0];

endmodule

[rtl/core/spq_ctrl.sv]
// Controller of the sorted priority queue: command sequencing and result registers.
module spq_ctrl #(
    parameter int CAPACITY = spq_pkg::CAPACITY,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_action,
    output spq_pkg::t_dp_cmd    o_cmd,
    input  spq_pkg::t_dp_stat   i_stat,
    input  logic [CW-1:0]       i_count,
    input  logic signed [31:0]  i_head_value,
    input  logic signed [31:0]  i_head_priority,
    output logic                o_strobe,
    output logic [2:0]          o_status,
    output logic signed [31:0]  o_out_value,
    output logic signed [31:0]  o_out_priority,
    output logic                o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DISP
    } t_state;

    t_state             r_state;
    logic [1:0]         r_action;
    logic [CW-1:0]      r_left;
    logic               r_strobe;
    logic               r_last;
    spq_pkg::t_status   r_status;
    logic signed [31:0] r_value;
    logic signed [31:0] r_priority;

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && start;
        o_cmd.insert  = (r_state == S_EXEC) && (r_action == spq_pkg::ACT_INSERT)
                        && !i_stat.full;
        o_cmd.rotate  = (r_state == S_DISP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_strobe <= 1'b0;
                    if (start) begin
                        r_action <= i_action;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_value    <= '0;
                    r_priority <= '0;
                    r_last     <= 1'b1;
                    unique case (r_action)
                        spq_pkg::ACT_INSERT: begin
                            r_state  <= S_IDLE;
                            r_strobe <= 1'b1;
                            r_status <= i_stat.full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
                        end
                        spq_pkg::ACT_DISPLAY: begin
                            if (i_stat.empty) begin
                                r_state  <= S_IDLE;
                                r_strobe <= 1'b1;
                                r_status <= spq_pkg::ST_EMPTY;
                            end else begin
                                r_strobe <= 1'b0;
                                r_left   <= i_count;
                                r_state  <= S_DISP;
                            end
                        end
                        spq_pkg::ACT_SEARCH: begin
                            r_state  <= S_IDLE;
                            r_strobe <= 1'b1;
                            if (i_stat.empty) begin
                                r_status <= spq_pkg::ST_EMPTY;
                            end else if (i_stat.found) begin
                                r_status <= spq_pkg::ST_FOUND;
                            end else begin
                                r_status <= spq_pkg::ST_NOTFOUND;
                            end
                        end
                        default: begin
                            r_state  <= S_IDLE;
                            r_strobe <= 1'b0;
                        end
                    endcase
                end
                S_DISP: begin
                    r_strobe   <= 1'b1;
                    r_status   <= spq_pkg::ST_LISTED;
                    r_value    <= i_head_value;
                    r_priority <= i_head_priority;
                    r_last     <= (r_left == CW'(1));
                    r_left     <= r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b0;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_value    = r_value;
    assign o_out_priority = r_priority;
    assign o_last         = r_last;

endmodule

[rtl/core/spq_checker.sv]
// Port-level assertions for the sorted priority queue, bound to the top level.
module spq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [2:0]  o_status,
    input logic [31:0] o_out_value,
    input logic [31:0] o_out_priority,
    input logic        o_last
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted item");

    a_stream_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe && (o_status == spq_pkg::ST_LISTED))
        else $error("display stream broken before its last entry");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != spq_pkg::ST_LISTED) |->
            o_last && (o_out_value == '0) && (o_out_priority == '0))
        else $error("single result not marked last or payload not zero");

    a_stream_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("block idle while a display stream continues");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_status      (o_status),
    .o_out_value   (o_out_value),
    .o_out_priority(o_out_priority),
    .o_last        (o_last)
);
